[rtl/core/ddwc_pkg.sv]
package ddwc_pkg;

    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned DAY_W     = 5;
    localparam int unsigned DIST_W    = 22;
    localparam int unsigned WDAY_W    = 3;
    localparam int unsigned HOL_W     = 4;
    localparam int unsigned DNUM_W    = 23;
    localparam int unsigned Q100_W    = 8;
    localparam int unsigned DBM_W     = 9;
    localparam int unsigned ADJ_W     = 12;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 32;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 2**14.
    localparam int unsigned RECIP100_W     = 13;
    localparam int unsigned RECIP100_SHIFT = 19;
    localparam logic [RECIP100_W-1:0] RECIP100 = 13'd5243;
    localparam int unsigned PROD100_W = YEAR_W + RECIP100_W;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [HOL_W-1:0] HOL_NONE  = 4'd0;
    localparam logic [HOL_W-1:0] HOL_JAN01 = 4'd1;
    localparam logic [HOL_W-1:0] HOL_FEB14 = 4'd2;
    localparam logic [HOL_W-1:0] HOL_MAR08 = 4'd3;
    localparam logic [HOL_W-1:0] HOL_MAR12 = 4'd4;
    localparam logic [HOL_W-1:0] HOL_APR01 = 4'd5;
    localparam logic [HOL_W-1:0] HOL_APR04 = 4'd6;
    localparam logic [HOL_W-1:0] HOL_MAY01 = 4'd7;
    localparam logic [HOL_W-1:0] HOL_JUN01 = 4'd8;
    localparam logic [HOL_W-1:0] HOL_AUG01 = 4'd9;
    localparam logic [HOL_W-1:0] HOL_SEP10 = 4'd10;
    localparam logic [HOL_W-1:0] HOL_OCT01 = 4'd11;
    localparam logic [HOL_W-1:0] HOL_DEC25 = 4'd12;

    // Date after the first stage: raw fields plus the two quotients by 100.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [YEAR_W-1:0]  prev;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [Q100_W-1:0]  yq100;
        logic [Q100_W-1:0]  pq100;
        logic               year_ok;
    } t_s1_date;

    // Date after the second stage: the partial sums of its day number.
    typedef struct packed {
        logic [DNUM_W-1:0] ny365;
        logic [ADJ_W-1:0]  nyadj;
        logic [DBM_W-1:0]  dbm;
        logic [DAY_W-1:0]  day;
        logic              ok;
    } t_s2_date;

    // Days before the month in a common year; zero for a month that does not exist.
    function automatic logic [DBM_W-1:0] f_days_before(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] r;
        case (m)
            MONTH_JAN: r = 9'd0;
            MONTH_FEB: r = 9'd31;
            MONTH_MAR: r = 9'd59;
            MONTH_APR: r = 9'd90;
            MONTH_MAY: r = 9'd120;
            MONTH_JUN: r = 9'd151;
            MONTH_JUL: r = 9'd181;
            MONTH_AUG: r = 9'd212;
            MONTH_SEP: r = 9'd243;
            MONTH_OCT: r = 9'd273;
            MONTH_NOV: r = 9'd304;
            MONTH_DEC: r = 9'd334;
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

    // Length of the month in a common year; zero marks a month that does not exist.
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        case (m)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: r = 5'd31;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: r = 5'd30;
            MONTH_FEB: r = 5'd28;
            default:   r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [HOL_W-1:0] f_holiday(input logic [MONTH_W-1:0] m,
                                                   input logic [DAY_W-1:0]   d);
        logic [HOL_W-1:0] r;
        r = HOL_NONE;
        case (m)
            MONTH_JAN: if (d == 5'd1)  r = HOL_JAN01;
            MONTH_FEB: if (d == 5'd14) r = HOL_FEB14;
            MONTH_MAR: begin
                if (d == 5'd8)       r = HOL_MAR08;
                else if (d == 5'd12) r = HOL_MAR12;
            end
            MONTH_APR: begin
                if (d == 5'd1)      r = HOL_APR01;
                else if (d == 5'd4) r = HOL_APR04;
            end
            MONTH_MAY: if (d == 5'd1)  r = HOL_MAY01;
            MONTH_JUN: if (d == 5'd1)  r = HOL_JUN01;
            MONTH_AUG: if (d == 5'd1)  r = HOL_AUG01;
            MONTH_SEP: if (d == 5'd10) r = HOL_SEP10;
            MONTH_OCT: if (d == 5'd1)  r = HOL_OCT01;
            MONTH_DEC: if (d == 5'd25) r = HOL_DEC25;
            default:   r = HOL_NONE;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/date_distance_weekday_calc_top.sv]
// Gregorian date distance and weekday calculator. Each input beat carries a query date and a
// reference date; each output beat gives the absolute number of days between them, the weekday
// of the query date (0 Sunday to 6 Saturday), the fixed-date holiday code of the query date and
// an error flag, raised with all other fields zero when either date has a year outside
// 1..MAX_YEAR, a month outside 1..12 or a day that the month does not have. The block takes one
// beat per cycle while the output is not stalled, and each result passes through the five register
// stages (quotients by 100, leap test and partial sums, day numbers, difference and weekday digit
// sum, output register). A stall on the output holds every stage.
module date_distance_weekday_calc_top #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // query_year[13:0], query_month[17:14], query_day[22:18],
    // ref_year[36:23], ref_month[40:37], ref_day[45:41], zero fill [47:46]
    input  logic [ddwc_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // day_distance[21:0], weekday[24:22], holiday_code[28:25], zero fill [31:29]
    output logic [ddwc_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // date_error[0]
    output logic                            o_m_axis_tuser
);
    import ddwc_pkg::*;

    logic w_adv;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    t_s1_date          n_s1 [2];
    t_s1_date          r_s1 [2];
    t_s2_date          n_s2 [2];
    t_s2_date          r_s2 [2];
    logic [DNUM_W-1:0] n_dn [2];
    logic [DNUM_W-1:0] r_dn [2];
    logic              n_ok3;
    logic              r_ok3;
    logic [HOL_W-1:0]  n_hol1;
    logic [HOL_W-1:0]  r_hol1, r_hol2, r_hol3, r_hol4;
    logic [DNUM_W-1:0] n_dist;
    logic [DNUM_W-1:0] r_dist;
    logic [5:0]        n_wsum;
    logic [5:0]        r_wsum;
    logic              r_ok4;

    logic [DIST_W-1:0] n_out_dist;
    logic [WDAY_W-1:0] n_out_wday;
    logic [HOL_W-1:0]  n_out_hol;
    logic              n_out_err;
    logic [DIST_W-1:0] r_out_dist;
    logic [WDAY_W-1:0] r_out_wday;
    logic [HOL_W-1:0]  r_out_hol;
    logic              r_out_err;

    assign w_adv           = ~r_v5 | i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_v5;
    assign o_m_axis_tdata  = {{(M_TDATA_W - DIST_W - WDAY_W - HOL_W){1'b0}},
                              r_out_hol, r_out_wday, r_out_dist};
    assign o_m_axis_tuser  = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Stage 1: year range check, the quotients of year and year - 1 by 100, and the query date's holiday code.
    always_comb begin
        logic [YEAR_W-1:0]    yr [2];
        logic [PROD100_W-1:0] py;
        logic [PROD100_W-1:0] pp;
        yr[0] = i_s_axis_tdata[13:0];
        yr[1] = i_s_axis_tdata[36:23];
        n_s1[0].month = i_s_axis_tdata[17:14];
        n_s1[0].day   = i_s_axis_tdata[22:18];
        n_s1[1].month = i_s_axis_tdata[40:37];
        n_s1[1].day   = i_s_axis_tdata[45:41];
        for (int i = 0; i < 2; i++) begin
            n_s1[i].year    = yr[i];
            n_s1[i].prev    = yr[i] - YEAR_W'(1);
            n_s1[i].year_ok = (yr[i] != '0) && (32'(yr[i]) <= 32'(MAX_YEAR));
            py = PROD100_W'(yr[i]) * PROD100_W'(RECIP100);
            pp = PROD100_W'(n_s1[i].prev) * PROD100_W'(RECIP100);
            n_s1[i].yq100 = py[RECIP100_SHIFT +: Q100_W];
            n_s1[i].pq100 = pp[RECIP100_SHIFT +: Q100_W];
        end
        n_hol1 = f_holiday(n_s1[0].month, n_s1[0].day);
    end

    // Stage 2: leap test, date check and the partial sums of the day number.
    always_comb begin
        logic [YEAR_W-1:0] rem;
        logic              leap;
        logic [DAY_W-1:0]  len;
        for (int i = 0; i < 2; i++) begin
            rem  = r_s1[i].year - YEAR_W'(r_s1[i].yq100) * YEAR_W'(100);
            // Divisible by 400 exactly when divisible by 100 with a quotient divisible by 4.
            leap = ((rem != '0) && (r_s1[i].year[1:0] == 2'b00)) ||
                   ((rem == '0) && (r_s1[i].yq100[1:0] == 2'b00));
            len  = f_month_len(r_s1[i].month);
            if ((r_s1[i].month == MONTH_FEB) && leap) begin
                len = len + DAY_W'(1);
            end
            n_s2[i].ok    = r_s1[i].year_ok && (len != '0) &&
                            (r_s1[i].day != '0) && (r_s1[i].day <= len);
            n_s2[i].ny365 = DNUM_W'(r_s1[i].prev) * DNUM_W'(365);
            n_s2[i].nyadj = ADJ_W'(r_s1[i].prev >> 2) - ADJ_W'(r_s1[i].pq100)
                          + ADJ_W'(r_s1[i].pq100 >> 2);
            n_s2[i].dbm   = f_days_before(r_s1[i].month)
                          + DBM_W'((r_s1[i].month > MONTH_FEB) && leap);
            n_s2[i].day   = r_s1[i].day;
        end
    end

    // Stage 3: day numbers, with 0001-01-01 as day 1.
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_dn[i] = r_s2[i].ny365 + DNUM_W'(r_s2[i].nyadj)
                    + DNUM_W'(r_s2[i].dbm) + DNUM_W'(r_s2[i].day);
        end
        n_ok3 = r_s2[0].ok && r_s2[1].ok;
    end

    // Stage 4: distance, and the sum of the octal digits of the query day number,
    // which keeps its value modulo 7 because 8 leaves 1.
    always_comb begin
        logic [DNUM_W:0] padded;
        n_dist = (r_dn[0] >= r_dn[1]) ? (r_dn[0] - r_dn[1]) : (r_dn[1] - r_dn[0]);
        padded = {1'b0, r_dn[0]};
        n_wsum = '0;
        for (int k = 0; k < 8; k++) begin
            n_wsum = n_wsum + 6'(padded[3*k +: 3]);
        end
    end

    // Stage 5: fold the digit sum to a weekday and zero the fields of an invalid beat.
    always_comb begin
        logic [3:0] t;
        t = 4'(r_wsum[5:3]) + 4'(r_wsum[2:0]);
        if (t >= 4'd7) begin
            t = t - 4'd7;
        end
        if (t >= 4'd7) begin
            t = t - 4'd7;
        end
        n_out_err  = ~r_ok4;
        n_out_dist = r_ok4 ? r_dist[DIST_W-1:0] : '0;
        n_out_wday = r_ok4 ? t[WDAY_W-1:0] : '0;
        n_out_hol  = r_ok4 ? r_hol4 : HOL_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1       <= n_s1;
            r_hol1     <= n_hol1;
            r_s2       <= n_s2;
            r_hol2     <= r_hol1;
            r_dn       <= n_dn;
            r_ok3      <= n_ok3;
            r_hol3     <= r_hol2;
            r_dist     <= n_dist;
            r_wsum     <= n_wsum;
            r_ok4      <= r_ok3;
            r_hol4     <= r_hol3;
            r_out_dist <= n_out_dist;
            r_out_wday <= n_out_wday;
            r_out_hol  <= n_out_hol;
            r_out_err  <= n_out_err;
        end
    end

endmodule

[bench/ddwc_result_checker.sv]
`timescale 1ns / 100ps

module ddwc_result_checker #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_valid,
    input  logic                           i_s_ready,
    input  logic [ddwc_pkg::S_TDATA_W-1:0] i_s_data,
    input  logic                           i_m_valid,
    input  logic                           i_m_ready,
    input  logic [ddwc_pkg::M_TDATA_W-1:0] i_m_data,
    input  logic                           i_m_user,
    output int                             o_fail_count,
    output int                             o_pending
);
    import ddwc_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [WDAY_W-1:0] weekday;
        logic [HOL_W-1:0]  holiday;
        logic              error;
    } t_date_answer;

    t_date_answer answers_due[$];
    int           fails   = 0;
    int           reports = 0;

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // A month that does not exist has length zero, so no day can be valid in it.
    function automatic int days_in_month(input int y, input logic [MONTH_W-1:0] m);
        case (m)
            MONTH_FEB: return leap_year(y) ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: return 31;
            default: return 0;
        endcase
    endfunction

    function automatic bit date_valid(input int y, input logic [MONTH_W-1:0] m, input int d);
        int len;
        len = days_in_month(y, m);
        return (y >= 1) && (y <= MAX_YEAR) && (len != 0) && (d >= 1) && (d <= len);
    endfunction

    // Counts days from the start of the calendar; the first of January in year one is day 1.
    function automatic int day_index(input int y, input logic [MONTH_W-1:0] m, input int d);
        int               p;
        int               n;
        logic [MONTH_W-1:0] k;
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (k = MONTH_JAN; k < m; k++)
            n += days_in_month(y, k);
        return n + d;
    endfunction

    function automatic logic [HOL_W-1:0] holiday_for(input logic [MONTH_W-1:0] m,
                                                     input logic [DAY_W-1:0]   d);
        case ({m, d})
            {MONTH_JAN, 5'd1}:  return HOL_JAN01;
            {MONTH_FEB, 5'd14}: return HOL_FEB14;
            {MONTH_MAR, 5'd8}:  return HOL_MAR08;
            {MONTH_MAR, 5'd12}: return HOL_MAR12;
            {MONTH_APR, 5'd1}:  return HOL_APR01;
            {MONTH_APR, 5'd4}:  return HOL_APR04;
            {MONTH_MAY, 5'd1}:  return HOL_MAY01;
            {MONTH_JUN, 5'd1}:  return HOL_JUN01;
            {MONTH_AUG, 5'd1}:  return HOL_AUG01;
            {MONTH_SEP, 5'd10}: return HOL_SEP10;
            {MONTH_OCT, 5'd1}:  return HOL_OCT01;
            {MONTH_DEC, 5'd25}: return HOL_DEC25;
            default:            return HOL_NONE;
        endcase
    endfunction

    function automatic t_date_answer answer_for(input logic [S_TDATA_W-1:0] beat);
        t_date_answer       a;
        logic [YEAR_W-1:0]  qy;
        logic [MONTH_W-1:0] qm;
        logic [DAY_W-1:0]   qd;
        logic [YEAR_W-1:0]  ry;
        logic [MONTH_W-1:0] rm;
        logic [DAY_W-1:0]   rd;
        int                 nq;
        int                 nr;
        {rd, rm, ry, qd, qm, qy} = beat[45:0];
        a = '0;
        if (!date_valid(int'(qy), qm, int'(qd)) || !date_valid(int'(ry), rm, int'(rd))) begin
            a.error = 1'b1;
            return a;
        end
        nq = day_index(int'(qy), qm, int'(qd));
        nr = day_index(int'(ry), rm, int'(rd));
        a.distance = DIST_W'((nq >= nr) ? nq - nr : nr - nq);
        a.weekday  = WDAY_W'(nq % 7);
        a.holiday  = holiday_for(qm, qd);
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_date_answer want;
        t_date_answer got;
        if (!i_rst_n) begin
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_s_valid && i_s_ready)
                answers_due.push_back(answer_for(i_s_data));
            if (i_m_valid && i_m_ready) begin
                got = {i_m_data[21:0], i_m_data[24:22], i_m_data[28:25], i_m_user};
                if (answers_due.size() == 0) begin
                    fails++;
                    if (reports < 10)
                        $display({"%0t: unexpected result beat: distance %0d weekday %0d",
                                  " holiday %0d error %0b"},
                                 $realtime, got.distance, got.weekday, got.holiday,
                                 got.error);
                    reports++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.distance != got.distance || want.weekday != got.weekday ||
                        want.holiday != got.holiday || want.error != got.error) begin
                        fails++;
                        if (reports < 10)
                            $display({"%0t: mismatch: distance %0d/%0d weekday %0d/%0d",
                                      " holiday %0d/%0d error %0b/%0b (expected/actual)"},
                                     $realtime, want.distance, got.distance, want.weekday,
                                     got.weekday, want.holiday, got.holiday, want.error,
                                     got.error);
                        reports++;
                    end
                end
            end
            o_pending    <= answers_due.size();
            o_fail_count <= fails;
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import ddwc_pkg::*;

    localparam int MAX_YEAR     = 9999;
    localparam int RANDOM_ITEMS = 1100;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 60;
    localparam int TX_IDLE[3]   = '{9, 58, 0};
    localparam int RX_IDLE[3]   = '{58, 9, 0};

    localparam logic [MONTH_W-1:0] HOLIDAY_MONTH[12] = '{
        MONTH_JAN, MONTH_FEB, MONTH_MAR, MONTH_MAR, MONTH_APR, MONTH_APR,
        MONTH_MAY, MONTH_JUN, MONTH_AUG, MONTH_SEP, MONTH_OCT, MONTH_DEC};
    localparam logic [DAY_W-1:0] HOLIDAY_DAY[12] = '{
        5'd1, 5'd14, 5'd8, 5'd12, 5'd1, 5'd4, 5'd1, 5'd1, 5'd1, 5'd10, 5'd1, 5'd25};

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data  = '0;
    logic                 m_ready = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [M_TDATA_W-1:0] m_data;
    logic                 m_user;
    int                   fail_count;
    int                   pending;
    int                   idle_phase  = 0;
    int                   quiet_count = 0;
    int                   hold_left   = 0;
    bit                   hold_done   = 1'b0;

    always #1 clk = ~clk;

    date_distance_weekday_calc_top #(.MAX_YEAR(MAX_YEAR)) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    ddwc_result_checker #(.MAX_YEAR(MAX_YEAR)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_m_user     (m_user),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [S_TDATA_W-1:0] dates_beat(
        input logic [YEAR_W-1:0] qy, input logic [MONTH_W-1:0] qm, input logic [DAY_W-1:0] qd,
        input logic [YEAR_W-1:0] ry, input logic [MONTH_W-1:0] rm, input logic [DAY_W-1:0] rd);
        return {2'b00, rd, rm, ry, qd, qm, qy};
    endfunction

    // Century edges are where the leap rules differ, so they get a good share of the years.
    function automatic logic [YEAR_W-1:0] pick_year();
        case ($urandom_range(9))
            0, 1:    return YEAR_W'($urandom_range(1, 99) * 100 - 1 + $urandom_range(0, 2));
            2:       return YEAR_W'($urandom_range(1, 40));
            3:       return YEAR_W'($urandom_range(MAX_YEAR - 40, MAX_YEAR));
            default: return YEAR_W'($urandom_range(1, MAX_YEAR));
        endcase
    endfunction

    // Mostly days that every month has; the rest probe the month ends.
    function automatic logic [DAY_W-1:0] pick_day();
        return DAY_W'(($urandom_range(9) < 8) ? $urandom_range(1, 28) : $urandom_range(29, 31));
    endfunction

    function automatic logic [MONTH_W-1:0] pick_month();
        return MONTH_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_beat();
        logic [YEAR_W-1:0]  qy;
        logic [MONTH_W-1:0] qm;
        logic [DAY_W-1:0]   qd;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return dates_beat(YEAR_W'($urandom_range(0, 16383)), MONTH_W'($urandom_range(0, 15)),
                              DAY_W'($urandom_range(0, 31)), YEAR_W'($urandom_range(0, 16383)),
                              MONTH_W'($urandom_range(0, 15)), DAY_W'($urandom_range(0, 31)));
        qy = pick_year();
        qm = pick_month();
        qd = pick_day();
        if (pick < 13)
            return dates_beat(qy, qm, qd, qy, qm, qd);
        if (pick < 18)
            return dates_beat(qy, qm, qd, qy + YEAR_W'($urandom_range(0, 1)), pick_month(),
                              pick_day());
        return dates_beat(qy, qm, qd, pick_year(), pick_month(), pick_day());
    endfunction

    task automatic offer_dates(input logic [S_TDATA_W-1:0] beat);
        while ($urandom_range(99) < TX_IDLE[idle_phase]) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
    endtask

    // The receiver side; on entering the last phase it holds off long enough to back up the
    // pipeline while the sender keeps offering beats.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (idle_phase == 2 && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= RX_IDLE[idle_phase]);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_count <= 0;
            else
                quiet_count <= quiet_count + 1;
            if (quiet_count >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_dates(dates_beat(14'd1, MONTH_JAN, 5'd1, YEAR_W'(MAX_YEAR), MONTH_DEC, 5'd31));
        offer_dates(dates_beat(YEAR_W'(MAX_YEAR), MONTH_DEC, 5'd31, 14'd1, MONTH_JAN, 5'd1));
        offer_dates(dates_beat(14'd2000, MONTH_FEB, 5'd29, 14'd2000, MONTH_FEB, 5'd29));
        offer_dates(dates_beat(14'd1900, MONTH_FEB, 5'd29, 14'd2000, MONTH_JAN, 5'd1));
        offer_dates(dates_beat(14'd2004, MONTH_FEB, 5'd29, 14'd1999, MONTH_MAR, 5'd1));
        offer_dates(dates_beat(14'd2023, 4'd0, 5'd10, 14'd2023, MONTH_MAY, 5'd10));
        offer_dates(dates_beat(14'd2023, 4'd13, 5'd10, 14'd2023, MONTH_MAY, 5'd10));
        offer_dates(dates_beat(14'd2023, MONTH_MAY, 5'd10, 14'd2023, 4'd15, 5'd10));
        offer_dates(dates_beat(14'd2023, MONTH_JUN, 5'd0, 14'd2023, MONTH_MAY, 5'd10));
        offer_dates(dates_beat(14'd2023, MONTH_APR, 5'd31, 14'd2023, MONTH_MAY, 5'd10));
        offer_dates(dates_beat(14'd2023, MONTH_MAY, 5'd10, 14'd0, MONTH_MAY, 5'd10));
        offer_dates(dates_beat(YEAR_W'(MAX_YEAR + 1), MONTH_JAN, 5'd1,
                               14'd2023, MONTH_MAY, 5'd10));
        offer_dates(dates_beat(14'h3FFF, 4'hF, 5'h1F, 14'h3FFF, 4'hF, 5'h1F));
        for (k = 0; k < 12; k++)
            offer_dates(dates_beat(pick_year(), HOLIDAY_MONTH[k], HOLIDAY_DAY[k],
                                   pick_year(), pick_month(), DAY_W'($urandom_range(1, 28))));

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 3)
                idle_phase <= 1;
            else if (k == 2 * RANDOM_ITEMS / 3)
                idle_phase <= 2;
            offer_dates(random_beat());
        end
        s_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
